// ----- rtl/btmx_pkg.sv -----
// ----------------------------------------------------------------------------
// btmx_pkg: shared types for the max-xor trie block
// Control word that the walk sequencer hands to the row of bit cells.
// ----------------------------------------------------------------------------
package btmx_pkg;

  typedef struct packed {
    logic load;     // take a fresh value, clear the xor bit
    logic v_shift;  // rotate the value one place toward the top
    logic a_shift;  // shift the xor result one place, new bit at the bottom
    logic acc_in;   // xor bit decided at this level
  } btmx_cell_ctl_t;

endpackage

// ----- rtl/btmx_ram.sv -----
// ----------------------------------------------------------------------------
// btmx_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module btmx_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/btmx_cell.sv -----
// ----------------------------------------------------------------------------
// btmx_cell: one bit position of the value and of the xor result
// Value bits rotate up the row one level a cycle while v_shift is set; xor
// bits shift in at the bottom as the query decides them.
// ----------------------------------------------------------------------------
module btmx_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  btmx_pkg::btmx_cell_ctl_t ctl_i,
  input  logic                    v_load_i,
  input  logic                    v_prev_i,
  input  logic                    a_prev_i,
  output logic                    v_o,
  output logic                    a_o
);
  import btmx_pkg::*;

  logic v_q, v_d;
  logic a_q, a_d;

  always_comb begin
    v_d = v_q;
    a_d = a_q;
    if (ctl_i.load) begin
      v_d = v_load_i;
      a_d = 1'b0;
    end else begin
      if (ctl_i.v_shift) begin
        v_d = v_prev_i;
      end
      if (ctl_i.a_shift) begin
        a_d = a_prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      a_q <= 1'b0;
    end else begin
      v_q <= v_d;
      a_q <= a_d;
    end
  end

  assign v_o = v_q;
  assign a_o = a_q;

endmodule

// ----- rtl/binary_trie_max_xor.sv -----
// ----------------------------------------------------------------------------
// binary_trie_max_xor: running maximum-xor pair over a binary trie
// Queries each value against the stored set, then inserts it.
// ----------------------------------------------------------------------------
// Each item runs a query walk over all VALUE_BITS levels (skipped when the
// set is empty), an insert walk of up to VALUE_BITS levels, a closing state
// and an idle state in which the next item is taken; no new item is taken
// until the last one is back in idle. The walk is shorter on an empty set or
// an overflow, and the closing state holds while the output is stalled. The
// result is registered in the closing state. The walk makes one child-table
// read per level through the single read port. The value and the xor result
// sit in a row of bit cells that rotates one level per cycle of the walk. A
// restart item empties the set as it is taken: the root lives in flops and
// nodes are handed out in order, each written when allocated with null in
// the child it does not get (the last with null children), so no clearing
// pass runs after reset. When the node store runs out the insert stops and
// overflow is flagged; the value is then not counted as stored.
// ----------------------------------------------------------------------------
module binary_trie_max_xor #(
  parameter int VALUE_BITS    = 31,
  parameter int NODE_CAPACITY = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] best_xor_o,
  output logic [VALUE_BITS-1:0] running_max_o,
  output logic                  had_earlier_o,
  output logic                  overflow_o
);
  import btmx_pkg::*;

  localparam int NW = $clog2(NODE_CAPACITY);
  localparam int FW = $clog2(NODE_CAPACITY + 1);
  localparam int LW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int EW = 2 * NW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QRY,
    ST_INS,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [LW-1:0]       cnt_q;
  logic [NW-1:0]       node_q;
  logic                fresh_q;
  logic                dead_q;
  logic                ovf_q;
  logic                earlier_q;
  logic [FW-1:0]       free_q;
  logic [EW-1:0]       root_q;
  logic [VALUE_BITS-1:0] best_so_far_q;
  logic                nonempty_q;
  logic                out_valid_q;
  logic [VALUE_BITS-1:0] best_xor_q;
  logic [VALUE_BITS-1:0] running_max_q;
  logic                had_earlier_q;
  logic                overflow_q;

  // cell row
  btmx_cell_ctl_t        ctl;
  logic [VALUE_BITS-1:0] v_vec;
  logic [VALUE_BITS-1:0] a_vec;
  logic                  acc_bit;

  for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
    logic v_prev, a_prev;
    if (k == 0) begin : g_bot
      assign v_prev = v_vec[VALUE_BITS-1];
      assign a_prev = ctl.acc_in;
    end else begin : g_mid
      assign v_prev = v_vec[k-1];
      assign a_prev = a_vec[k-1];
    end
    btmx_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .v_load_i (value_i[k]),
      .v_prev_i (v_prev),
      .a_prev_i (a_prev),
      .v_o      (v_vec[k]),
      .a_o      (a_vec[k])
    );
  end

  // child table
  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  btmx_ram #(
    .Width (EW),
    .Depth (NODE_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // walk datapath
  logic          in_acc;
  logic          out_free;
  logic          last;
  logic          bit_cur;
  logic [EW-1:0] entry;
  logic [NW-1:0] c0, c1, want, same, adv_node, new_node;
  logic          alive;
  logic          need_alloc;
  logic          full;
  logic [EW-1:0] upd_entry;
  logic          better;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (cnt_q == '0);
  assign bit_cur  = v_vec[VALUE_BITS-1];

  always_comb begin
    if (node_q == '0) begin
      entry = root_q;
    end else if (fresh_q) begin
      entry = '0;
    end else begin
      entry = ram_rdata;
    end
  end

  assign c0         = entry[NW-1:0];
  assign c1         = entry[EW-1:NW];
  assign want       = bit_cur ? c0 : c1;
  assign same       = bit_cur ? c1 : c0;
  assign adv_node   = (want != '0) ? want : same;
  assign alive      = !dead_q && ((want != '0) || (same != '0));
  assign acc_bit    = !dead_q && (want != '0);
  assign need_alloc = (same == '0);
  assign full       = (free_q >= FW'(NODE_CAPACITY));
  assign new_node   = free_q[NW-1:0];
  assign upd_entry  = bit_cur ? {new_node, c0} : {c1, new_node};
  assign better     = earlier_q && (a_vec > best_so_far_q);

  always_comb begin
    ctl         = '0;
    ctl.load    = in_acc;
    ctl.v_shift = (state_q == ST_QRY) || (state_q == ST_INS);
    ctl.a_shift = (state_q == ST_QRY);
    ctl.acc_in  = (state_q == ST_QRY) && acc_bit;
  end

  always_comb begin
    if (state_q == ST_QRY) begin
      ram_raddr = adv_node;
    end else if (need_alloc) begin
      ram_raddr = new_node;
    end else begin
      ram_raddr = same;
    end
  end

  // parent gets its new child link; the last fresh node gets null children
  assign ram_we    = ((state_q == ST_INS) && need_alloc && !full && (node_q != '0)) ||
                     ((state_q == ST_FIN) && fresh_q);
  assign ram_waddr = node_q;
  assign ram_wdata = (state_q == ST_FIN) ? '0 : upd_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      node_q        <= '0;
      fresh_q       <= 1'b0;
      dead_q        <= 1'b0;
      ovf_q         <= 1'b0;
      earlier_q     <= 1'b0;
      free_q        <= FW'(1);
      root_q        <= '0;
      best_so_far_q <= '0;
      nonempty_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      best_xor_q    <= '0;
      running_max_q <= '0;
      had_earlier_q <= 1'b0;
      overflow_q    <= 1'b0;
    end else begin
      // the closing state sets a new item itself when the output is free
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q   <= LW'(VALUE_BITS - 1);
            node_q  <= '0;
            fresh_q <= 1'b0;
            dead_q  <= 1'b0;
            ovf_q   <= 1'b0;
            if (restart_i) begin
              root_q        <= '0;
              free_q        <= FW'(1);
              best_so_far_q <= '0;
              nonempty_q    <= 1'b0;
              earlier_q     <= 1'b0;
              state_q       <= ST_INS;
            end else begin
              earlier_q <= nonempty_q;
              state_q   <= nonempty_q ? ST_QRY : ST_INS;
            end
          end
        end
        ST_QRY: begin
          if (alive) begin
            node_q <= adv_node;
          end else begin
            dead_q <= 1'b1;
          end
          if (last) begin
            state_q <= ST_INS;
            node_q  <= '0;
            cnt_q   <= LW'(VALUE_BITS - 1);
          end else begin
            cnt_q <= cnt_q - LW'(1);
          end
        end
        ST_INS: begin
          cnt_q <= cnt_q - LW'(1);
          if (need_alloc && full) begin
            ovf_q   <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            if (need_alloc) begin
              free_q  <= free_q + FW'(1);
              node_q  <= new_node;
              fresh_q <= 1'b1;
              if (node_q == '0) begin
                root_q <= upd_entry;
              end
            end else begin
              node_q  <= same;
              fresh_q <= 1'b0;
            end
            if (last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            best_xor_q    <= a_vec;
            running_max_q <= better ? a_vec : best_so_far_q;
            had_earlier_q <= earlier_q;
            overflow_q    <= ovf_q;
            if (better) begin
              best_so_far_q <= a_vec;
            end
            if (!ovf_q) begin
              nonempty_q <= 1'b1;
            end
            fresh_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign best_xor_o    = best_xor_q;
  assign running_max_o = running_max_q;
  assign had_earlier_o = had_earlier_q;
  assign overflow_o    = overflow_q;

  // checks
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !had_earlier_o |-> best_xor_o == '0)
    else $error("best_xor nonzero with empty set");

  a_max_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_xor_o <= running_max_o)
    else $error("running_max below best_xor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("item taken while walk not started");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FW'(NODE_CAPACITY) && free_q != '0)
    else $error("node allocator out of range");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for binary_trie_max_xor
// Sends values in short sets of clustered values with restarts between them.
// A trie model in the testbench predicts each result, and a monitor checks
// every result against the oldest prediction. The sender idles in bursts
// and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VBITS    = 31;
  localparam int NODES    = 65536;
  localparam int IDLE_MAX = 40000;

  typedef struct {
    logic [VBITS-1:0] value;
    logic             restart;
    logic             drain_first;  // hold off until all results are back
  } trie_item_t;

  typedef struct {
    logic [VBITS-1:0] best_xor;
    logic [VBITS-1:0] running_max;
    logic             had_earlier;
    logic             overflow;
  } xor_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [VBITS-1:0] value_i;
  logic             restart_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [VBITS-1:0] best_xor_o;
  logic [VBITS-1:0] running_max_o;
  logic             had_earlier_o;
  logic             overflow_o;

  binary_trie_max_xor #(
    .VALUE_BITS   (VBITS),
    .NODE_CAPACITY(NODES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .best_xor_o   (best_xor_o),
    .running_max_o(running_max_o),
    .had_earlier_o(had_earlier_o),
    .overflow_o   (overflow_o)
  );

  trie_item_t  pending_items[$];
  xor_result_t expected_results[$];
  int          fail_count;
  int          idle_cycles;
  bit          stim_done;

  // trie model
  int unsigned kid0[NODES];
  int unsigned kid1[NODES];
  int unsigned free_node;
  logic [VBITS-1:0] set_best;
  bit          set_has_values;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void empty_trie();
    kid0[0] = 0;
    kid1[0] = 0;
    free_node = 1;
    set_best = '0;
    set_has_values = 1'b0;
  endfunction

  function automatic xor_result_t predict_max_xor(logic [VBITS-1:0] v, logic rst_set);
    xor_result_t r;
    int unsigned node;
    int unsigned want;
    int unsigned same;
    int unsigned nxt;
    logic [VBITS-1:0] acc;
    if (rst_set) empty_trie();
    acc = '0;
    r.had_earlier = set_has_values;
    if (set_has_values) begin
      node = 0;
      for (int b = VBITS - 1; b >= 0; b--) begin
        want = v[b] ? kid0[node] : kid1[node];
        same = v[b] ? kid1[node] : kid0[node];
        if (want != 0) begin
          acc[b] = 1'b1;
          node = want;
        end else if (same != 0) begin
          node = same;
        end else begin
          break;
        end
      end
      if (acc > set_best) set_best = acc;
    end
    r.overflow = 1'b0;
    node = 0;
    for (int b = VBITS - 1; b >= 0; b--) begin
      nxt = v[b] ? kid1[node] : kid0[node];
      if (nxt == 0) begin
        if (free_node >= NODES) begin
          r.overflow = 1'b1;
          break;
        end
        nxt = free_node;
        free_node++;
        kid0[nxt] = 0;
        kid1[nxt] = 0;
        if (v[b]) kid1[node] = nxt;
        else kid0[node] = nxt;
      end
      node = nxt;
    end
    if (!r.overflow) set_has_values = 1'b1;
    r.best_xor = acc;
    r.running_max = set_best;
    return r;
  endfunction

  task automatic add_item(logic [VBITS-1:0] v, logic rs, logic dr = 1'b0);
    trie_item_t it;
    it.value = v;
    it.restart = rs;
    it.drain_first = dr;
    pending_items.push_back(it);
  endtask

  // stimulus
  initial begin
    logic [VBITS-1:0] base;
    int set_len;
    int low_bits;
    fail_count = 0;
    stim_done = 1'b0;
    empty_trie();
    // directed: empty set, extremes, duplicates, restart
    add_item('0, 1'b0);
    add_item('1, 1'b0);
    add_item('0, 1'b0);
    add_item('1, 1'b0);
    add_item(31'h4000_0000, 1'b0);
    add_item(31'h2AAA_AAAA, 1'b0);
    add_item(31'h5555_5555, 1'b0);
    add_item('1, 1'b1);
    add_item('1, 1'b0);
    add_item(31'h0000_0001, 1'b0);
    add_item(31'h0000_0000, 1'b1, 1'b1);
    add_item(31'h3FFF_FFFF, 1'b0);
    add_item(31'h4000_0000, 1'b0);
    add_item(31'h0000_0001, 1'b1);
    add_item(31'h0000_0000, 1'b0);
    add_item(31'h0000_0003, 1'b0);
    // short sets, values clustered so paths share prefixes
    while (pending_items.size() < 1200) begin
      set_len = $urandom_range(1, 40);
      base = VBITS'($urandom);
      low_bits = $urandom_range(1, VBITS);
      for (int i = 0; i < set_len; i++) begin
        logic [VBITS-1:0] v;
        v = VBITS'($urandom);
        if ($urandom_range(0, 3) != 0)
          v = (base & ~((VBITS'(1) << low_bits) - VBITS'(1))) |
              (v & ((VBITS'(1) << low_bits) - VBITS'(1)));
        if (low_bits == VBITS) v = VBITS'($urandom);
        add_item(v, i == 0, (i == 0) && ($urandom_range(0, 15) == 0));
      end
    end
    // extremes against a random set, then a fresh set
    add_item(VBITS'($urandom), 1'b1, 1'b1);
    add_item('1, 1'b0);
    add_item('0, 1'b0);
    add_item(VBITS'($urandom), 1'b1, 1'b1);
    for (int i = 0; i < 20; i++) add_item(VBITS'($urandom), 1'b0);
    stim_done = 1'b1;
  end

  // driver
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      restart_i  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(predict_max_xor(value_i, restart_i));
      if (!(in_valid_i && in_stall_o)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 70);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first ||
                      (expected_results.size() == 0 && !in_valid_i))) begin
          in_valid_i <= 1'b1;
          value_i    <= pending_items[0].value;
          restart_i  <= pending_items[0].restart;
          void'(pending_items.pop_front());
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase;
  int stall_pct;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase = 0;
      stall_pct   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: best_xor %h", best_xor_o);
          fail_count++;
        end else begin
          xor_result_t e;
          e = expected_results.pop_front();
          if (best_xor_o !== e.best_xor) begin
            $error("best_xor: expected %h, got %h", e.best_xor, best_xor_o);
            fail_count++;
          end
          if (running_max_o !== e.running_max) begin
            $error("running_max: expected %h, got %h", e.running_max, running_max_o);
            fail_count++;
          end
          if (had_earlier_o !== e.had_earlier) begin
            $error("had_earlier: expected %b, got %b", e.had_earlier, had_earlier_o);
            fail_count++;
          end
          if (overflow_o !== e.overflow) begin
            $error("overflow: expected %b, got %b", e.overflow, overflow_o);
            fail_count++;
          end
        end
      end
      if (stall_phase == 0) begin
        stall_phase = $urandom_range(20, 400);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
      end
      stall_phase--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
